FILE: src/swmv_pkg.sv
// Package for the sliding window mean / variance block.
// Types, register map and fixed field widths; no dependencies.
`default_nettype none
package swmv_pkg;

    localparam int MEAN_W     = 24;   // window_mean field
    localparam int VAR_W      = 39;   // window_variance field
    localparam int WLEN_W     = 7;    // window_length register
    localparam int WLEN_RESET = 16;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [PADDR_W-1:0] ADDR_WINDOW_LENGTH = 3'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ACC,
        S_MUL,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_VAR_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;     // latch incoming sample
        logic push;        // write history, square terms
        logic accum;       // update running sums
        logic mul;         // products for variance
        logic start_mean;  // launch divider on mean
        logic take_mean;   // store mean, launch divider on variance
        logic load_out;    // move results to output register
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

FILE: src/swmv_sample_if.sv
// Sample channel: valid/ready handshake carrying one signed sample word.
// Depends on nothing.
`default_nettype none
interface swmv_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

FILE: src/swmv_result_if.sv
// Result channel: valid/ready handshake carrying mean and variance.
// Depends on swmv_pkg for the field widths.
`default_nettype none
interface swmv_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [swmv_pkg::MEAN_W-1:0] window_mean;
    logic        [swmv_pkg::VAR_W-1:0]  window_variance;

    modport source (output valid, output window_mean, output window_variance, input ready);
    modport sink   (input valid, input window_mean, input window_variance, output ready);
endinterface
`default_nettype wire

FILE: src/swmv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module swmv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/swmv_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module swmv_div #(
    parameter int DW = 53,   // dividend / quotient bits
    parameter int VW = 14    // divisor bits
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quot,
    output logic               o_rem_nz
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_q, n_q;
    logic [VW-1:0] r_rem, n_rem;
    logic [VW-1:0] r_d, n_d;
    logic [VW:0]   trial, diff;
    logic          ge;

    always_comb begin
        trial = {r_rem, r_q[DW-1]};
        diff  = trial - {1'b0, r_d};
        ge    = trial >= {1'b0, r_d};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DW);
            n_q    = i_dividend;
            n_rem  = '0;
            n_d    = i_divisor;
        end else if (r_busy) begin
            n_q   = {r_q[DW-2:0], ge};
            n_rem = ge ? diff[VW-1:0] : trial[VW-1:0];
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_done   = r_done;
    assign o_quot   = r_q;
    assign o_rem_nz = r_rem != '0;
endmodule
`default_nettype wire

FILE: src/swmv_datapath.sv
// Datapath: history RAM, running sums, products, divider, output register.
// Depends on swmv_pkg, swmv_ram and swmv_div.
`default_nettype none
module swmv_datapath #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire swmv_pkg::t_cmd                      i_cmd,
    output swmv_pkg::t_status                        o_status,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  wire logic                                i_cfg_we,
    input  wire logic [swmv_pkg::WLEN_W-1:0]         i_cfg_wlen,
    output logic      [swmv_pkg::WLEN_W-1:0]         o_wlen,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [swmv_pkg::MEAN_W-1:0]       o_mean,
    output logic        [swmv_pkg::VAR_W-1:0]        o_var
);
    localparam int SB   = SAMPLE_BITS;
    localparam int LW   = $clog2(WINDOW_MAX + 1);
    localparam int AW   = $clog2(WINDOW_MAX);
    localparam int SUMW = SB + LW;
    localparam int SQW  = 2 * SB + LW;
    localparam int PW   = SQW + LW;
    localparam int DW0  = PW + 8;
    localparam int DW   = (DW0 > swmv_pkg::VAR_W + 1) ? DW0 : swmv_pkg::VAR_W + 1;
    localparam int VW   = 2 * LW;
    localparam int EW   = swmv_pkg::WLEN_W + LW;

    logic [swmv_pkg::WLEN_W-1:0] r_wlen;
    logic [LW-1:0]               n_eff;
    logic [EW-1:0]               wl_ext;

    logic signed [SB-1:0]   r_s;
    logic signed [SB-1:0]   r_leave;
    logic [2*SB-1:0]        r_sqs, r_sql;
    logic signed [SUMW-1:0] r_sum;
    logic [SQW-1:0]         r_sumsq;
    logic [PW-1:0]          r_p1, r_p2;
    logic [VW-1:0]          r_nn;
    logic [AW-1:0]          r_wp;
    logic [LW-1:0]          r_cnt;
    logic                   r_neg;

    logic [AW-1:0]          raddr;
    logic [SB-1:0]          rdata;
    logic signed [SB-1:0]   leave;
    logic signed [2*SB-1:0] sq_s, sq_l;
    logic signed [2*SUMW-1:0] sum_sq;
    logic [SUMW-1:0]        sum_abs;

    logic          div_start, div_done, div_nz;
    logic [DW-1:0] div_dvd, div_q, mean_full;
    logic [VW-1:0] div_dvs;

    logic                               r_ovalid;
    logic signed [swmv_pkg::MEAN_W-1:0] r_mean_hold;
    logic        [swmv_pkg::VAR_W-1:0]  r_var;
    logic signed [swmv_pkg::MEAN_W-1:0] r_mean;

    // clamp: zero counts as one, beyond the history depth as the depth
    always_comb begin
        wl_ext = EW'(r_wlen);
        if (r_wlen == '0) begin
            n_eff = LW'(1);
        end else if (wl_ext > EW'(WINDOW_MAX)) begin
            n_eff = LW'(WINDOW_MAX);
        end else begin
            n_eff = wl_ext[LW-1:0];
        end
    end

    // oldest sample in window sits n words behind the write pointer
    always_comb begin
        if ((LW + 1)'(r_wp) >= (LW + 1)'(n_eff)) begin
            raddr = AW'((LW + 1)'(r_wp) - (LW + 1)'(n_eff));
        end else begin
            raddr = AW'((LW + 1)'(r_wp) + (LW + 1)'(WINDOW_MAX) - (LW + 1)'(n_eff));
        end
    end

    swmv_ram #(.WIDTH(SB), .DEPTH(WINDOW_MAX)) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_wp),
        .i_wdata (r_s),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // words never written since the last clear read as zero
    assign leave   = (r_cnt >= n_eff) ? $signed(rdata) : '0;
    assign sq_s    = r_s * r_s;
    assign sq_l    = leave * leave;
    assign sum_sq  = r_sum * r_sum;
    assign sum_abs = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen  <= swmv_pkg::WLEN_W'(swmv_pkg::WLEN_RESET);
            r_sum   <= '0;
            r_sumsq <= '0;
            r_wp    <= '0;
            r_cnt   <= '0;
        end else if (i_cfg_we) begin
            r_wlen  <= i_cfg_wlen;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_wp    <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.push) begin
                r_wp <= (r_wp == AW'(WINDOW_MAX - 1)) ? '0 : r_wp + AW'(1);
                if (r_cnt != LW'(WINDOW_MAX)) begin
                    r_cnt <= r_cnt + LW'(1);
                end
            end
            if (i_cmd.accum) begin
                r_sum   <= r_sum - SUMW'(r_leave) + SUMW'(r_s);
                r_sumsq <= r_sumsq - SQW'(r_sql) + SQW'(r_sqs);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_s <= i_sample;
        end
        if (i_cmd.push) begin
            r_leave <= leave;
            r_sqs   <= (2*SB)'(sq_s);
            r_sql   <= (2*SB)'(sq_l);
        end
        if (i_cmd.mul) begin
            r_p1  <= PW'(r_sumsq) * PW'(n_eff);
            r_p2  <= PW'(sum_sq);
            r_nn  <= VW'(n_eff) * VW'(n_eff);
            r_neg <= r_sum[SUMW-1];
        end
    end

    assign div_start = i_cmd.start_mean | i_cmd.take_mean;
    always_comb begin
        if (i_cmd.take_mean) begin
            div_dvd = DW'({r_p1 - r_p2, 8'd0});
            div_dvs = r_nn;
        end else begin
            div_dvd = DW'({sum_abs, 8'd0});
            div_dvs = VW'(n_eff);
        end
    end

    swmv_div #(.DW(DW), .VW(VW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem_nz   (div_nz)
    );

    // floor for negative sums: negate and round the magnitude up
    assign mean_full = r_neg ? (DW'(0) - div_q - DW'(div_nz)) : div_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_mean) begin
            r_mean_hold <= mean_full[swmv_pkg::MEAN_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_mean <= r_mean_hold;
            r_var  <= div_q[swmv_pkg::VAR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_ovalid || i_ready;
    assign o_wlen  = r_wlen;
    assign o_valid = r_ovalid;
    assign o_mean  = r_mean;
    assign o_var   = r_var;
endmodule
`default_nettype wire

FILE: src/swmv_ctrl.sv
// Controller FSM sequencing one sample through the datapath.
// Depends on swmv_pkg.
`default_nettype none
module swmv_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire swmv_pkg::t_status i_status,
    output swmv_pkg::t_cmd         o_cmd
);
    swmv_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swmv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            swmv_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = swmv_pkg::S_SQ;
                end
            end
            swmv_pkg::S_SQ: begin
                o_cmd.push = 1'b1;
                n_state = swmv_pkg::S_ACC;
            end
            swmv_pkg::S_ACC: begin
                o_cmd.accum = 1'b1;
                n_state = swmv_pkg::S_MUL;
            end
            swmv_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = swmv_pkg::S_MEAN_GO;
            end
            swmv_pkg::S_MEAN_GO: begin
                o_cmd.start_mean = 1'b1;
                n_state = swmv_pkg::S_MEAN_WAIT;
            end
            swmv_pkg::S_MEAN_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.take_mean = 1'b1;
                    n_state = swmv_pkg::S_VAR_WAIT;
                end
            end
            swmv_pkg::S_VAR_WAIT: begin
                if (i_status.div_done) begin
                    n_state = swmv_pkg::S_DONE;
                end
            end
            swmv_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = swmv_pkg::S_IDLE;
                end
            end
            default: n_state = swmv_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: src/sliding_window_mean_variance_top.sv
// Top level of the sliding window mean / variance block.
// Depends on swmv_pkg, both channel interfaces, swmv_ctrl and swmv_datapath.
//
// Usage: samples arrive on i_smp (valid/ready); each accepted word yields one
// result word on o_res holding the floored mean and population variance of
// the newest window_length samples, both with 8 fraction bits.
// window_length is written over the APB port at byte address 0; a write
// clears the history and the running sums (the history is cleared through a
// fill count, so no sweep is needed). Configure only while idle.
// Each accepted sample passes through the restoring divider twice, once for
// the mean and once for the variance; DW, the divider width, is PW + 8 = 54
// bits at the default parameters. One sample is in work at a time: a new
// word is taken only after the previous result is loaded.
// The result sits in an output register: the next sample is taken while a
// result still waits, and a stalled receiver only holds the block once the
// following result is ready to be loaded.
// Reset: history counts as zeros, sums zero, window_length 16.
`default_nettype none
module sliding_window_mean_variance_top #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    swmv_sample_if.sink                                i_smp,
    swmv_result_if.source                              o_res,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [swmv_pkg::PADDR_W-1:0]          paddr,
    input  wire logic [swmv_pkg::PDATA_W-1:0]          pwdata,
    output logic      [swmv_pkg::PDATA_W-1:0]          prdata,
    output logic                                       pready
);
    swmv_pkg::t_cmd              cmd;
    swmv_pkg::t_status           status;
    logic                        cfg_we;
    logic [swmv_pkg::WLEN_W-1:0] wlen;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == swmv_pkg::ADDR_WINDOW_LENGTH);
    assign prdata = (paddr == swmv_pkg::ADDR_WINDOW_LENGTH)
                  ? swmv_pkg::PDATA_W'(wlen) : '0;

    swmv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_smp.valid),
        .o_ready  (i_smp.ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    swmv_datapath #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_sample   (i_smp.sample),
        .i_cfg_we   (cfg_we),
        .i_cfg_wlen (pwdata[swmv_pkg::WLEN_W-1:0]),
        .o_wlen     (wlen),
        .o_valid    (o_res.valid),
        .i_ready    (o_res.ready),
        .o_mean     (o_res.window_mean),
        .o_var      (o_res.window_variance)
    );
endmodule
`default_nettype wire

FILE: tb/sv/tb_swmv_if.sv
// Shared types for the sliding window mean / variance testbench.
// Depends on swmv_pkg for the field widths.
`timescale 1ns / 1ps
package tb_swmv_types;
    typedef struct {
        logic signed [swmv_pkg::MEAN_W-1:0] mean;
        logic        [swmv_pkg::VAR_W-1:0]  variance;
    } t_stats;
endpackage

FILE: tb/sv/tb_sliding_window_mean_variance_top.sv
// Testbench for sliding_window_mean_variance_top: APB writes of window_length,
// directed and random samples, results checked against a behavioural predictor.
// Depends on swmv_pkg, swmv_sample_if, swmv_result_if and tb_swmv_types.
`timescale 1ns / 1ps
module tb_sliding_window_mean_variance_top;
    localparam int WMAX = 64;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [swmv_pkg::PADDR_W-1:0] paddr = '0;
    logic [swmv_pkg::PDATA_W-1:0] pwdata = '0;
    logic [swmv_pkg::PDATA_W-1:0] prdata;
    logic pready;

    swmv_sample_if #(.SAMPLE_BITS(16)) smp ();
    swmv_result_if res ();

    sliding_window_mean_variance_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_smp(smp.sink), .o_res(res.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic signed [15:0] hist [WMAX];
    logic signed [22:0] win_sum;
    logic        [36:0] win_sq_sum;
    logic        [6:0]  wlen_reg;
    tb_swmv_types::t_stats stats_q[$];
    int  errors = 0;
    int  send_idle = 27, recv_idle = 74;

    function automatic logic [36:0] square16(logic signed [15:0] x);
        longint v;
        v = x;
        return v * v;
    endfunction

    task automatic clear_window();
        foreach (hist[i]) hist[i] = '0;
        win_sum = '0;
        win_sq_sum = '0;
    endtask

    function automatic int eff_window();
        if (wlen_reg == 0) return 1;
        if (wlen_reg > WMAX) return WMAX;
        return wlen_reg;
    endfunction

    function automatic tb_swmv_types::t_stats window_stats(logic signed [15:0] s);
        int n;
        logic signed [15:0] leaving;
        longint num, m, sm;
        logic [127:0] vnum;
        tb_swmv_types::t_stats r;
        n = eff_window();
        leaving = hist[n-1];
        for (int i = WMAX-1; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = s;
        win_sum = win_sum - leaving + s;
        win_sq_sum = win_sq_sum - square16(leaving) + square16(s);
        sm = win_sum;
        num = sm * 256;
        if (num >= 0) m = num / n;
        else m = -((-num + n - 1) / n);
        vnum = (128'(n) * 128'(win_sq_sum) - 128'(sm * sm)) * 256;
        r.mean = m[swmv_pkg::MEAN_W-1:0];
        r.variance = 39'(vnum / 128'(n * n));
        return r;
    endfunction

    task automatic apb_write(logic [6:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= swmv_pkg::ADDR_WINDOW_LENGTH;
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        wlen_reg = v;
        clear_window();
    endtask

    // one word: expectation pushed at the accepting edge; valid stays high
    // afterwards so back-to-back words need only one assignment per edge
    task automatic send_sample(logic signed [15:0] s, bit has_exp = 0,
                               tb_swmv_types::t_stats e = '{0, 0});
        tb_swmv_types::t_stats p;
        while ($urandom_range(99) < send_idle) begin
            smp.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp.valid <= 1'b1;
        smp.sample <= s;
        do @(posedge i_clk); while (!smp.ready);
        p = window_stats(s);
        if (has_exp) begin
            if (p.mean !== e.mean) begin
                $error("window_mean exp %0d got %0d", e.mean, p.mean);
                errors++;
            end
            if (p.variance !== e.variance) begin
                $error("window_variance exp %0d got %0d", e.variance, p.variance);
                errors++;
            end
            stats_q.push_back(e);
        end else begin
            stats_q.push_back(p);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        smp.valid <= 1'b0;
        while (stats_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (300) @(posedge i_clk);
    endtask

    // receiver side
    always @(posedge i_clk) begin
        tb_swmv_types::t_stats e;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                if (stats_q.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    e = stats_q.pop_front();
                    if (res.window_mean !== e.mean) begin
                        $error("window_mean exp %0d got %0d", e.mean, res.window_mean);
                        errors++;
                    end
                    if (res.window_variance !== e.variance) begin
                        $error("window_variance exp %0d got %0d", e.variance,
                               res.window_variance);
                        errors++;
                    end
                end
            end
            res.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    typedef struct {
        logic signed [15:0]    s;
        bit                    has_exp;
        tb_swmv_types::t_stats e;
    } t_row;

    initial begin
        t_row rows[$];
        int wl_set[$];
        smp.valid = 1'b0;
        smp.sample = '0;
        res.ready = 1'b0;
        wlen_reg = 7'(swmv_pkg::WLEN_RESET);
        clear_window();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset, window 16 of zeros: one sample x gives mean 16*x, var from sums
        rows.push_back('{16'sd16, 1, '{24'sd256, 39'd3840}});
        rows.push_back('{16'sd0, 0, '{0, 0}});
        rows.push_back('{-16'sd32768, 0, '{0, 0}});
        rows.push_back('{16'sd32767, 0, '{0, 0}});
        rows.push_back('{-16'sd1, 0, '{0, 0}});
        foreach (rows[i]) send_sample(rows[i].s, rows[i].has_exp, rows[i].e);
        drain();

        // window of one, zero (used as one), above max, max
        apb_write(7'd1);
        send_sample(16'sd32767, 1, '{24'sd8388352, 39'd0});
        send_sample(-16'sd32768, 1, '{-24'sd8388608, 39'd0});
        drain();
        apb_write(7'd0);
        send_sample(-16'sd5, 1, '{-24'sd1280, 39'd0});
        drain();
        apb_write(7'd127);
        for (int i = 0; i < 70; i++) send_sample(i[0] ? 16'sd32767 : -16'sd32768);
        drain();
        apb_write(7'd64);
        for (int i = 0; i < 66; i++) send_sample(-16'sd32768);
        drain();

        wl_set = '{3, 64, 2, 1, 37, 16};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin send_idle = 74; recv_idle = 27; end
            if (ph == 4) begin send_idle = 0; recv_idle = 0; end
            apb_write(7'(wl_set[ph]));
            for (int i = 0; i < 80; i++) begin
                case ($urandom_range(3))
                    0: send_sample($urandom_range(1) ? 16'sd32767 : -16'sd32768);
                    1: send_sample(16'($signed($urandom_range(200)) - 100));
                    default: send_sample(16'($urandom));
                endcase
            end
            drain();
        end
        if (errors == 0 && stats_q.size() == 0) begin
            $display("tb_sliding_window_mean_variance_top OK");
        end else begin
            $display("tb_sliding_window_mean_variance_top NOT OK");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_sliding_window_mean_variance_top NOT OK");
        $finish;
    end
endmodule
